// File: hw/rtl/pcl_pkg.sv
// shared types and constants for the panel controller link model
`timescale 1ns / 1ps

package pcl_pkg;

  // item mode codes
  localparam logic [2:0] MODE_REPLY   = 3'd0;
  localparam logic [2:0] MODE_OBSERVE = 3'd1;
  localparam logic [2:0] MODE_SERVICE = 3'd2;
  localparam logic [2:0] MODE_ARM_DSP = 3'd3;
  localparam logic [2:0] MODE_ARM_LD  = 3'd4;
  localparam logic [2:0] MODE_CANCEL  = 3'd5;

  // configuration register indexes
  localparam logic [7:0] CFG_POLL_INTERVAL = 8'd0;
  localparam logic [7:0] CFG_AUTOPOLL_ON   = 8'd1;
  localparam logic [7:0] CFG_LIVE_POLL     = 8'd2;
  localparam logic [7:0] CFG_STATUS_REPLY  = 8'd3;

  // configuration reset values
  localparam logic [63:0] RST_POLL_INTERVAL = 64'd1000000;
  localparam logic [7:0]  RST_STATUS_REPLY  = 8'hff;

  // host bytes and answers
  localparam logic [7:0] BYTE_CAL_POLL   = 8'hfd;
  localparam logic [7:0] BYTE_CAL_ANSWER = 8'hc9;
  localparam logic [7:0] BYTE_CAL_DONE   = 8'hff;
  localparam logic [7:0] BYTE_STATUS_A   = 8'he7;
  localparam logic [7:0] BYTE_STATUS_B   = 8'hf0;
  localparam logic [7:0] BYTE_NULL_REQ   = 8'h71;
  localparam logic [7:0] BYTE_NULL_ANS   = 8'h00;
  localparam logic [1:0] CAL_MAX         = 2'd3;

  // display frame bytes
  localparam logic [7:0] BYTE_FRAME_END   = 8'hf7;
  localparam logic [7:0] BYTE_FRAME_DELIM = 8'h66;

  // autopoll boot gates
  localparam logic [15:0] MIN_DISK_READS = 16'd124;
  localparam logic [63:0] BOOT_CYCLES    = 64'd50000000;

  // input item
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  byte_value;
    logic [7:0]  frame_count;
    logic        live_run;
    logic [15:0] disk_read_count;
    logic [63:0] cycle_count;
    logic        link_idle;
  } pcl_in_t;

  // result item
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       flag;
  } pcl_out_t;

  // configuration registers
  typedef struct packed {
    logic [63:0] poll_interval;
    logic        autopoll_on;
    logic        live_poll_allowed;
    logic [7:0]  status_reply_byte;
  } pcl_cfg_t;

endpackage

// File: hw/rtl/pcl_reply.sv
// reply path: host byte answers and calibration poll count
`timescale 1ns / 1ps

module pcl_reply (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pcl_pkg::pcl_in_t item_i,
  input  pcl_pkg::pcl_cfg_t cfg_i,
  output logic [7:0]       reply_o
);
  import pcl_pkg::*;

  logic [1:0] cal_q, cal_d;
  logic       is_cal;

  assign is_cal = (item_i.byte_value == BYTE_CAL_POLL);

  // answer selection
  always_comb begin
    if (is_cal) begin
      reply_o = (cal_q < CAL_MAX) ? BYTE_CAL_ANSWER : BYTE_CAL_DONE;
    end else if (item_i.byte_value == BYTE_STATUS_A || item_i.byte_value == BYTE_STATUS_B) begin
      reply_o = cfg_i.status_reply_byte;
    end else if (item_i.byte_value == BYTE_NULL_REQ) begin
      reply_o = BYTE_NULL_ANS;
    end else begin
      reply_o = item_i.byte_value;
    end
  end

  // saturating calibration count
  always_comb begin
    cal_d = cal_q;
    if (en_i && item_i.mode == MODE_REPLY && is_cal && cal_q < CAL_MAX) begin
      cal_d = cal_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 2'd0;
    end else begin
      cal_q <= cal_d;
    end
  end

endmodule

// File: hw/rtl/pcl_observe.sv
// observe path: display frame tracking with burst and ready-search countdowns
`timescale 1ns / 1ps

module pcl_observe #(
  parameter int unsigned READY_SEARCH_BYTES = 128,
  parameter int unsigned FRAME_BYTE_LIMIT   = 256,
  parameter int unsigned LOAD_FRAMES        = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pcl_pkg::pcl_in_t item_i,
  output logic             flag_o
);
  import pcl_pkg::*;

  localparam logic [7:0] SearchInit = 8'(READY_SEARCH_BYTES);
  localparam logic [8:0] BurstInit  = 9'(FRAME_BYTE_LIMIT);
  localparam logic [7:0] LoadFrames = 8'(LOAD_FRAMES);

  logic [7:0] frames_q, frames_d, obs_frames, arm_frames;
  logic [7:0] search_q, search_d, obs_search;
  logic [8:0] burst_q, burst_d, obs_burst;
  logic       is_end, is_delim;

  assign is_end   = (item_i.byte_value == BYTE_FRAME_END);
  assign is_delim = (item_i.byte_value == BYTE_FRAME_DELIM);

  // next counters and flag for an observed byte
  always_comb begin
    obs_frames = frames_q;
    obs_search = search_q;
    obs_burst  = burst_q;
    flag_o     = 1'b0;
    if (is_end && frames_q != 8'd0) begin
      // terminator counts off a frame and restarts the search
      obs_frames = frames_q - 8'd1;
      obs_burst  = 9'd0;
      obs_search = (obs_frames != 8'd0) ? SearchInit : 8'd0;
      flag_o     = (obs_frames != 8'd0);
    end else begin
      // delimiter closes or opens a burst
      if (is_delim && frames_q != 8'd0) begin
        if (burst_q != 9'd0) begin
          obs_frames = frames_q - 8'd1;
          obs_burst  = (obs_frames != 8'd0) ? BurstInit : 9'd0;
        end else begin
          obs_burst = BurstInit;
        end
        obs_search = 8'd0;
      end
      if (obs_burst != 9'd0) begin
        if (!is_delim) begin
          obs_burst = obs_burst - 9'd1;
        end
        if (obs_burst != 9'd0) begin
          flag_o = 1'b1;
        end else if (obs_frames != 8'd0) begin
          obs_search = SearchInit;
          flag_o     = 1'b1;
        end
      end else if (obs_frames != 8'd0 && obs_search != 8'd0) begin
        obs_search = obs_search - 8'd1;
        flag_o     = 1'b1;
      end
    end
  end

  // frame count loaded by the arm commands; cancel loads zero
  always_comb begin
    arm_frames = 8'd0;
    if (item_i.mode == MODE_ARM_DSP) begin
      arm_frames = item_i.frame_count;
    end else if (item_i.mode == MODE_ARM_LD) begin
      arm_frames = LoadFrames;
    end
  end

  // state update per mode
  always_comb begin
    frames_d = frames_q;
    search_d = search_q;
    burst_d  = burst_q;
    if (en_i) begin
      unique case (item_i.mode)
        MODE_OBSERVE: begin
          frames_d = obs_frames;
          search_d = obs_search;
          burst_d  = obs_burst;
        end
        MODE_ARM_DSP, MODE_ARM_LD, MODE_CANCEL: begin
          frames_d = arm_frames;
          search_d = (arm_frames != 8'd0) ? SearchInit : 8'd0;
          burst_d  = 9'd0;
        end
        default: begin
          frames_d = frames_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= 8'd0;
      search_q <= 8'd0;
      burst_q  <= 9'd0;
    end else begin
      frames_q <= frames_d;
      search_q <= search_d;
      burst_q  <= burst_d;
    end
  end

endmodule

// File: hw/rtl/pcl_service.sv
// service path: poll scheduling from cycle count, load budget and boot gates
`timescale 1ns / 1ps

module pcl_service #(
  parameter int unsigned LOAD_POLL_BUDGET = 20000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  pcl_pkg::pcl_in_t  item_i,
  input  pcl_pkg::pcl_cfg_t cfg_i,
  output logic              flag_o
);
  import pcl_pkg::*;

  localparam logic [14:0] BudgetInit = 15'(LOAD_POLL_BUDGET);

  logic [14:0] budget_q, budget_d;
  logic [63:0] last_q, last_d;
  logic [63:0] elapsed;
  logic        due, load_poll, auto_poll;

  // elapsed cycles since the last issued poll, modulo 2^64
  assign elapsed = item_i.cycle_count - last_q;
  assign due     = (elapsed >= cfg_i.poll_interval);

  assign load_poll = item_i.link_idle && (budget_q != 15'd0) && due;
  assign auto_poll = item_i.link_idle && cfg_i.autopoll_on &&
                     (!item_i.live_run || cfg_i.live_poll_allowed) &&
                     (item_i.disk_read_count >= MIN_DISK_READS) &&
                     (item_i.cycle_count >= BOOT_CYCLES) && due;
  assign flag_o    = load_poll || auto_poll;

  // budget and last poll time
  always_comb begin
    budget_d = budget_q;
    last_d   = last_q;
    if (en_i) begin
      unique case (item_i.mode)
        MODE_SERVICE: begin
          if (flag_o) begin
            last_d = item_i.cycle_count;
          end
          if (load_poll) begin
            budget_d = budget_q - 15'd1;
          end
        end
        MODE_ARM_LD: budget_d = BudgetInit;
        MODE_CANCEL: budget_d = 15'd0;
        default:     budget_d = budget_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= 15'd0;
      last_q   <= 64'd0;
    end else begin
      budget_q <= budget_d;
      last_q   <= last_d;
    end
  end

endmodule

// File: hw/rtl/panel_controller_link_model.sv
// top level of the panel controller link model
`timescale 1ns / 1ps
// an accepted request waits in the input register; when it advances its result
// is loaded into the result register, from which it is offered on the output
// throughput: one request per cycle, results flow back to back while not stalled
// the state update of each request is done when it advances, with its result load
// reset: counters, poll time and valid flags clear; configuration takes its
// reset values; requests of modes three to seven give no result

module panel_controller_link_model #(
  parameter int unsigned READY_SEARCH_BYTES = 128,
  parameter int unsigned FRAME_BYTE_LIMIT   = 256,
  parameter int unsigned LOAD_POLL_BUDGET   = 20000,
  parameter int unsigned LOAD_FRAMES        = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcl_pkg::pcl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcl_pkg::pcl_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);
  import pcl_pkg::*;

  pcl_cfg_t cfg_q, cfg_d;
  pcl_in_t  item_q;
  pcl_out_t res_d, res_q;
  logic     item_valid_q, item_valid_d;
  logic     out_valid_q, out_valid_d;
  logic     in_accept, advance, has_result, slot_free;
  logic [7:0] reply;
  logic     obs_flag, svc_flag;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLL_INTERVAL: cfg_d.poll_interval     = cfg_data_i;
        CFG_AUTOPOLL_ON:   cfg_d.autopoll_on       = cfg_data_i[0];
        CFG_LIVE_POLL:     cfg_d.live_poll_allowed = cfg_data_i[0];
        CFG_STATUS_REPLY:  cfg_d.status_reply_byte = cfg_data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval     <= RST_POLL_INTERVAL;
      cfg_q.autopoll_on       <= 1'b1;
      cfg_q.live_poll_allowed <= 1'b1;
      cfg_q.status_reply_byte <= RST_STATUS_REPLY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control
  assign has_result = (item_q.mode == MODE_REPLY) || (item_q.mode == MODE_OBSERVE) ||
                      (item_q.mode == MODE_SERVICE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && (!has_result || slot_free);
  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  // datapath units
  pcl_reply u_reply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .reply_o (reply)
  );

  pcl_observe #(
    .READY_SEARCH_BYTES (READY_SEARCH_BYTES),
    .FRAME_BYTE_LIMIT   (FRAME_BYTE_LIMIT),
    .LOAD_FRAMES        (LOAD_FRAMES)
  ) u_observe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .flag_o (obs_flag)
  );

  pcl_service #(
    .LOAD_POLL_BUDGET (LOAD_POLL_BUDGET)
  ) u_service (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .flag_o (svc_flag)
  );

  // result select
  always_comb begin
    res_d.reply_byte = 8'd0;
    res_d.flag       = 1'b0;
    case (item_q.mode)
      MODE_REPLY:   res_d.reply_byte = reply;
      MODE_OBSERVE: res_d.flag       = obs_flag;
      MODE_SERVICE: res_d.flag       = svc_flag;
      default:      res_d.flag       = 1'b0;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // an empty input register never stalls the sender
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> !in_stall_o)
    else $error("input stalled while input register empty");

  // a request with a result always lands in the result register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && has_result |=> out_valid_q)
    else $error("result of a request was lost");

  // a taken result with nothing behind it empties the result register
  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !(advance && has_result) |=> !out_valid_q)
    else $error("result repeated after it was taken");

endmodule
